// ----- hdl/owsp_pkg.sv -----
// Package for the omni wheel speed to PWM block: fixed widths, register map and the
// arctangent table used by the CORDIC stages.
// No dependencies.
`default_nettype none
package owsp_pkg;

	localparam int NumWheels = 4;
	// CORDIC datapath width: Q28 speed times the CORDIC growth stays below 2^33.
	localparam int XW = 34;
	// Wheel speed width after the rotation term is added (Q12).
	localparam int SW = 20;
	localparam int GainQ16 = 39797;
	localparam int AtanEntries = 24;

	typedef enum logic [1:0] {
		REG_DUTY_GAIN   = 2'd0,
		REG_DUTY_OFFSET = 2'd1,
		REG_DUTY_LIMIT  = 2'd2,
		REG_NONE        = 2'd3
	} reg_idx_t;

	typedef logic [31:0] atan_tab_t [0:AtanEntries-1];

	localparam atan_tab_t AtanTurn32 = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
		32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
	};

	// Arctangent of 2^-i in units of 2^-ab turn, rounded to nearest.
	function automatic logic [32:0] atan_round(input int i, input int ab);
		logic [32:0] t;
		t = {1'b0, AtanTurn32[i]} + (33'd1 << (31 - ab));
		return t >> (32 - ab);
	endfunction

endpackage
`default_nettype wire

// ----- hdl/owsp_if.sv -----
// Valid/ready channel interfaces for the omni wheel block: the command channel and
// the wheel command result channel. Independent of the package.
`default_nettype none
interface owsp_cmd_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] travel_speed;
	logic [15:0]        travel_heading;
	logic signed [15:0] spin_speed;
	logic [15:0]        body_attitude;

	modport source (output valid, travel_speed, travel_heading, spin_speed, body_attitude,
		input ready);
	modport sink (input valid, travel_speed, travel_heading, spin_speed, body_attitude,
		output ready);
endinterface

interface owsp_wheel_if;
	logic       valid;
	logic       ready;
	logic       dir_wheel1;
	logic [9:0] duty_wheel1;
	logic       dir_wheel2;
	logic [9:0] duty_wheel2;
	logic       dir_wheel3;
	logic [9:0] duty_wheel3;
	logic       dir_wheel4;
	logic [9:0] duty_wheel4;

	modport source (output valid, dir_wheel1, duty_wheel1, dir_wheel2, duty_wheel2,
		dir_wheel3, duty_wheel3, dir_wheel4, duty_wheel4, input ready);
	modport sink (input valid, dir_wheel1, duty_wheel1, dir_wheel2, duty_wheel2,
		dir_wheel3, duty_wheel3, dir_wheel4, duty_wheel4, output ready);
endinterface
`default_nettype wire

// ----- hdl/omni_wheel_speed_to_pwm.sv -----
// Top level of the omni wheel speed to PWM block: pipelined CORDIC inverse kinematics
// for four wheels and duty scaling. Depends on owsp_pkg and the owsp_if interfaces.
//
//  Channel   Dir  Protocol     Payload
//  cmd       in   valid/ready  travel_speed, travel_heading, spin_speed, body_attitude
//  wheel     out  valid/ready  dir_wheelN, duty_wheelN for N = 1..4
//  apb       in   APB rd/wr    duty_gain, duty_offset, duty_limit at 0x0, 0x4, 0x8
//
// One command per cycle is taken while the pipeline is not stalled, with one
// register stage per CORDIC iteration plus angle setup, rounding, duty multiply and
// saturation. Each stage holds while the next one is full and stalled, so a bubble
// is squeezed out and nothing is lost or repeated. Reset clears the valid bits and
// returns the registers to their defaults.
`default_nettype none
module omni_wheel_speed_to_pwm #(
	parameter int ANGLE_BITS    = 16,
	parameter int CORDIC_STAGES = 16
) (
	input  wire             clk,
	input  wire             arst_n,
	owsp_cmd_if.sink        cmd,
	owsp_wheel_if.source    wheel,
	input  wire             psel,
	input  wire             penable,
	input  wire             pwrite,
	input  wire  [3:0]      paddr,
	input  wire  [31:0]     pwdata,
	output logic [31:0]     prdata,
	output logic            pready
);
	import owsp_pkg::*;

	localparam int ZW = ANGLE_BITS + 1;
	localparam int N  = CORDIC_STAGES;
	localparam int NS = N + 4;

	// Configuration registers.
	logic [15:0] duty_gain_q;
	logic [7:0]  duty_offset_q;
	logic [9:0]  duty_limit_q;
	reg_idx_t    reg_sel;

	assign reg_sel = reg_idx_t'(paddr[3:2]);
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			duty_gain_q   <= 16'd10812;
			duty_offset_q <= 8'd186;
			duty_limit_q  <= 10'd1023;
		end else if (psel && penable && pwrite) begin
			case (reg_sel)
				REG_DUTY_GAIN:   duty_gain_q   <= pwdata[15:0];
				REG_DUTY_OFFSET: duty_offset_q <= pwdata[7:0];
				REG_DUTY_LIMIT:  duty_limit_q  <= pwdata[9:0];
				default: ;
			endcase
		end
	end

	// Register readback.
	always_comb begin
		case (reg_sel)
			REG_DUTY_GAIN:   prdata = {16'd0, duty_gain_q};
			REG_DUTY_OFFSET: prdata = {24'd0, duty_offset_q};
			REG_DUTY_LIMIT:  prdata = {22'd0, duty_limit_q};
			default:         prdata = 32'd0;
		endcase
	end

	// Stage valid bits and advance chain; a stage loads when it is empty or drains.
	logic [NS-1:0] vld_q;
	logic [NS-1:0] adv;

	always_comb begin
		adv[NS-1] = !vld_q[NS-1] || wheel.ready;
		for (int k = NS - 2; k >= 0; k--) begin
			adv[k] = !vld_q[k] || adv[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (adv[0]) begin
				vld_q[0] <= cmd.valid;
			end
			for (int k = 1; k < NS; k++) begin
				if (adv[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	assign cmd.ready = adv[0];

	// CORDIC state per stage and wheel; index 0 is the angle setup stage.
	logic signed [XW-1:0] x_s   [0:N][0:NumWheels-1];
	logic signed [XW-1:0] y_s   [0:N][0:NumWheels-1];
	logic signed [ZW-1:0] z_s   [0:N][0:NumWheels-1];
	logic                 neg_s [0:N][0:NumWheels-1];
	logic signed [15:0]   spin_s [0:N];

	// Setup: wheel angle difference, quadrant fold and gain-compensated start vector.
	logic signed [32:0] x_init;
	assign x_init = cmd.travel_speed * 17'sd39797;

	for (genvar w = 0; w < NumWheels; w++) begin : g_setup
		logic [15:0]           d;
		logic [23:0]           dsh;
		logic [ANGLE_BITS-1:0] za;

		assign d   = cmd.travel_heading - cmd.body_attitude - 16'd8192 - 16'(16384 * w);
		assign dsh = {d, 8'h00} >> (24 - ANGLE_BITS);
		assign za  = dsh[ANGLE_BITS-1:0];

		always_ff @(posedge clk) begin
			if (adv[0]) begin
				x_s[0][w]   <= XW'(x_init);
				y_s[0][w]   <= '0;
				// Folding a half turn only touches the two top bits of the angle.
				z_s[0][w]   <= {{2{za[ANGLE_BITS-2]}}, za[ANGLE_BITS-2:0]};
				neg_s[0][w] <= za[ANGLE_BITS-1] ^ za[ANGLE_BITS-2];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv[0]) begin
			spin_s[0] <= cmd.spin_speed;
		end
	end

	// One CORDIC rotation per register stage.
	for (genvar i = 0; i < N; i++) begin : g_cordic
		localparam logic [32:0] AtanFull = atan_round(i, ANGLE_BITS);
		localparam logic signed [ZW-1:0] Atan = ZW'(AtanFull);

		for (genvar w = 0; w < NumWheels; w++) begin : g_lane
			always_ff @(posedge clk) begin
				if (adv[i+1]) begin
					if (!z_s[i][w][ZW-1]) begin
						x_s[i+1][w] <= x_s[i][w] - (y_s[i][w] >>> i);
						y_s[i+1][w] <= y_s[i][w] + (x_s[i][w] >>> i);
						z_s[i+1][w] <= z_s[i][w] - Atan;
					end else begin
						x_s[i+1][w] <= x_s[i][w] + (y_s[i][w] >>> i);
						y_s[i+1][w] <= y_s[i][w] - (x_s[i][w] >>> i);
						z_s[i+1][w] <= z_s[i][w] + Atan;
					end
					neg_s[i+1][w] <= neg_s[i][w];
				end
			end
		end

		always_ff @(posedge clk) begin
			if (adv[i+1]) begin
				spin_s[i+1] <= spin_s[i];
			end
		end
	end

	// Round the product to Q12, undo the fold and add the rotation term.
	logic signed [SW-1:0] spd_s2  [0:NumWheels-1];
	logic                 dir_s3  [0:NumWheels-1];
	logic [35:0]          prod_s3 [0:NumWheels-1];
	logic                 dir_s4  [0:NumWheels-1];
	logic [9:0]           duty_s4 [0:NumWheels-1];

	for (genvar w = 0; w < NumWheels; w++) begin : g_post
		logic signed [XW-1:0] xr;
		logic signed [SW-1:0] r;
		logic signed [SW-1:0] rs;
		logic [SW-1:0]        mag;
		logic [36:0]          acc;
		logic [16:0]          duty_full;

		assign xr  = (x_s[N][w] + XW'(34'sd32768)) >>> 16;
		assign r   = SW'(xr);
		assign rs  = neg_s[N][w] ? -r : r;
		assign mag = spd_s2[w][SW-1] ? SW'(-spd_s2[w]) : SW'(spd_s2[w]);
		assign acc = {1'b0, prod_s3[w]} + {17'd0, duty_offset_q, 12'd0};
		assign duty_full = acc[36:20];

		always_ff @(posedge clk) begin
			if (adv[N+1]) begin
				spd_s2[w] <= rs + SW'(spin_s[N]);
			end
			// Magnitude times gain.
			if (adv[N+2]) begin
				dir_s3[w]  <= spd_s2[w][SW-1];
				prod_s3[w] <= 36'(mag) * 36'(duty_gain_q);
			end
			// Offset, truncation and saturation.
			if (adv[N+3]) begin
				dir_s4[w]  <= dir_s3[w];
				duty_s4[w] <= (duty_full > {7'd0, duty_limit_q}) ? duty_limit_q
					: duty_full[9:0];
			end
		end
	end

	// Result channel.
	assign wheel.valid       = vld_q[NS-1];
	assign wheel.dir_wheel1  = dir_s4[0];
	assign wheel.duty_wheel1 = duty_s4[0];
	assign wheel.dir_wheel2  = dir_s4[1];
	assign wheel.duty_wheel2 = duty_s4[1];
	assign wheel.dir_wheel3  = dir_s4[2];
	assign wheel.duty_wheel3 = duty_s4[2];
	assign wheel.dir_wheel4  = dir_s4[3];
	assign wheel.duty_wheel4 = duty_s4[3];

endmodule
`default_nettype wire
